// ----- hdl/smpq_pkg.sv -----
package smpq_pkg;

  // Default number of entries held.
  localparam int DEFAULT_CAPACITY = 16;

  // Field widths fixed by the word format.
  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int ERR_W   = 2;
  localparam int COUNT_W = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // Head value reported while the store is empty.
  localparam logic signed [DATA_W-1:0] EMPTY_HEAD = -32'sd1;

  // One stored entry.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

endpackage

// ----- hdl/stable_min_priority_queue_top.sv -----
// Sorted priority queue held in a circular buffer of on-chip memory.
// Input channel: in_valid / in_stall with op, item_value, item_priority.
// A word is taken when in_valid is high and in_stall is low. op 0 inserts
// (value, priority) behind every entry of lower or equal priority, op 1
// removes the head, op 2 empties the store, op 3 changes nothing.
// Output channel: out_valid / out_stall with head_value, is_empty,
// entry_count and error_code; every input word gives one output word that
// describes the store after the operation.
// Dequeue, clear, no-op, any rejected operation and an enqueue into an empty
// store go straight to the head read-back; an enqueue into a non-empty store
// first walks back from the tail, moving each entry of greater priority one
// place back. The walk reads and writes the single entry memory one entry a
// cycle, and the head is read back from it after every operation. No new
// word is taken until the result of the last one is in the output register.
// After the last write, S_HEADRD reads the head and S_HEADWT loads the result.
// Reset empties the store at once; no clearing pass is needed.
// While out_stall holds a result, the next word may still be taken and
// worked on; its result waits until the output register is free.
module stable_min_priority_queue_top
  import smpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          op,
  input  logic signed [DATA_W-1:0] item_value,
  input  logic signed [DATA_W-1:0] item_priority,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] head_value,
  output logic                     is_empty,
  output logic [COUNT_W-1:0]       entry_count,
  output logic [ERR_W-1:0]         error_code
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + COUNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CMP    = 5'b00010,
    S_INS    = 5'b00100,
    S_HEADRD = 5'b01000,
    S_HEADWT = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    pos, pos_next;
  logic [CW-1:0]    remain, remain_next;
  logic [ERR_W-1:0] err, err_next;
  entry_t           new_entry;

  // Entry memory and its port signals.
  entry_t           mem [CAPACITY];
  entry_t           rd_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;

  logic             accept;
  logic             out_free;
  logic             load_out;
  logic [AW:0]      tail_sum;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    tail_m1;
  logic [AW-1:0]    pos_m1;
  logic [AW-1:0]    pos_m2;
  logic [AW-1:0]    head_p1;
  logic [EW-1:0]    count_wide;

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == '0) begin
      r = LAST_ADDR;
    end else begin
      r = a - AW'(1);
    end
    return r;
  endfunction

  // Circular buffer address arithmetic.
  assign tail_sum = {1'b0, head} + (AW + 1)'(count);
  assign tail     = (tail_sum >= (AW + 1)'(CAPACITY)) ?
                    AW'(tail_sum - (AW + 1)'(CAPACITY)) : tail_sum[AW-1:0];
  assign tail_m1  = addr_dec(tail);
  assign pos_m1   = addr_dec(pos);
  assign pos_m2   = addr_dec(pos_m1);
  assign head_p1  = (head == LAST_ADDR) ? '0 : head + AW'(1);

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_out = (state == S_HEADWT) && out_free;

  // The entry being inserted comes from the input word when it is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      new_entry.value <= item_value;
      new_entry.prio  <= item_priority;
    end
  end

  // Sequencer: insertion walk, head update and head read-back.
  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    pos_next    = pos;
    remain_next = remain;
    err_next    = err;
    rd_en       = 1'b0;
    rd_addr     = head;
    wr_en       = 1'b0;
    wr_addr     = pos;
    wr_data     = new_entry;
    case (state)
      S_IDLE: begin
        if (accept) begin
          err_next   = ERR_OK;
          state_next = S_HEADRD;
          case (op)
            OP_ENQUEUE: begin
              if (count == FULL_COUNT) begin
                err_next = ERR_FULL;
              end else if (count == '0) begin
                wr_en           = 1'b1;
                wr_addr         = head;
                wr_data.value   = item_value;
                wr_data.prio    = item_priority;
                count_next      = count + CW'(1);
              end else begin
                pos_next    = tail;
                remain_next = count;
                rd_en       = 1'b1;
                rd_addr     = tail_m1;
                state_next  = S_CMP;
              end
            end
            OP_DEQUEUE: begin
              if (count == '0) begin
                err_next = ERR_EMPTY;
              end else begin
                head_next  = head_p1;
                count_next = count - CW'(1);
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        if (rd_data.prio > new_entry.prio) begin
          // Move the greater entry one place back and look further ahead.
          wr_en       = 1'b1;
          wr_addr     = pos;
          wr_data     = rd_data;
          pos_next    = pos_m1;
          remain_next = remain - CW'(1);
          if (remain == CW'(1)) begin
            state_next = S_INS;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_m2;
          end
        end else begin
          wr_en      = 1'b1;
          wr_addr    = pos;
          count_next = count + CW'(1);
          state_next = S_HEADRD;
        end
      end
      S_INS: begin
        wr_en      = 1'b1;
        wr_addr    = pos;
        count_next = count + CW'(1);
        state_next = S_HEADRD;
      end
      S_HEADRD: begin
        rd_en      = 1'b1;
        rd_addr    = head;
        state_next = S_HEADWT;
      end
      S_HEADWT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    remain <= remain_next;
    err    <= err_next;
  end

  // Synchronous memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Output register for the result word.
  assign count_wide = EW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      head_value  <= (count == '0) ? EMPTY_HEAD : rd_data.value;
      is_empty    <= (count == '0);
      entry_count <= count_wide[COUNT_W-1:0];
      error_code  <= err;
    end
  end

  // The store never holds more entries than it has room for.
  assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("occupancy exceeds capacity");

  // A taken word blocks the input until its result has been loaded.
  assert property (@(posedge clk) disable iff (rst) accept |=> in_stall)
    else $error("input taken again before the result was formed");

  // The memory is never read and written at one address in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
                   (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write collide on one entry");

  // A new result only appears after the head has been read back.
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_HEADWT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded after head read-back");

  // An empty store reports the empty head value.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && is_empty) |-> (head_value == EMPTY_HEAD))
    else $error("empty store reports a head value");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import smpq_pkg::*;

  localparam int QUEUE_DEPTH = DEFAULT_CAPACITY;
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int RANDOM_WORDS = 900;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  // Status of the store as reported after one operation.
  typedef struct packed {
    logic signed [DATA_W-1:0] head;
    logic                     empty;
    logic [COUNT_W-1:0]       count;
    logic [ERR_W-1:0]         err;
  } queue_status_t;

  // Keeps its own sorted copy of the store and the statuses still owed by the block.
  class sorted_queue_scoreboard;
    logic signed [DATA_W-1:0] held_value [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] held_prio [QUEUE_DEPTH];
    int unsigned held_count;
    queue_status_t pending_status [$];
    int fail_count;
    int enq_words, deq_words, clear_words, nop_words;
    int full_rejects, empty_rejects, peak_count;

    function new();
      held_count = 0;
      fail_count = 0;
      enq_words = 0;
      deq_words = 0;
      clear_words = 0;
      nop_words = 0;
      full_rejects = 0;
      empty_rejects = 0;
      peak_count = 0;
    endfunction

    // Applies an accepted operation to the copy and queues the status it should give.
    function void note_operation(logic [OP_W-1:0] code, logic signed [DATA_W-1:0] value,
                                 logic signed [DATA_W-1:0] prio);
      queue_status_t want;
      int unsigned pos;
      want.err = ERR_OK;
      case (code)
        OP_ENQUEUE: begin
          enq_words++;
          if (held_count >= QUEUE_DEPTH) begin
            want.err = ERR_FULL;
            full_rejects++;
          end else begin
            // Only entries of strictly greater priority move back, so ties keep arrival order.
            pos = held_count;
            while (pos > 0 && held_prio[pos-1] > prio) begin
              held_value[pos] = held_value[pos-1];
              held_prio[pos] = held_prio[pos-1];
              pos--;
            end
            held_value[pos] = value;
            held_prio[pos] = prio;
            held_count++;
          end
        end
        OP_DEQUEUE: begin
          deq_words++;
          if (held_count == 0) begin
            want.err = ERR_EMPTY;
            empty_rejects++;
          end else begin
            for (int i = 1; i < held_count; i++) begin
              held_value[i-1] = held_value[i];
              held_prio[i-1] = held_prio[i];
            end
            held_count--;
          end
        end
        OP_CLEAR: begin
          clear_words++;
          held_count = 0;
        end
        default: nop_words++;
      endcase
      if (held_count > peak_count) peak_count = held_count;
      want.head = (held_count > 0) ? held_value[0] : EMPTY_HEAD;
      want.empty = (held_count == 0);
      want.count = held_count[COUNT_W-1:0];
      pending_status.push_back(want);
    endfunction

    // Compares one result word with the oldest status owed.
    function void check_status(logic signed [DATA_W-1:0] head, logic empty,
                               logic [COUNT_W-1:0] count, logic [ERR_W-1:0] err);
      queue_status_t want;
      if (pending_status.size() == 0) begin
        $error("result word arrived with no operation outstanding");
        fail_count++;
        return;
      end
      want = pending_status.pop_front();
      if (head !== want.head) begin
        $error("head_value: expected %0d, got %0d", want.head, head);
        fail_count++;
      end
      if (empty !== want.empty) begin
        $error("is_empty: expected %0d, got %0d", want.empty, empty);
        fail_count++;
      end
      if (count !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, count);
        fail_count++;
      end
      if (err !== want.err) begin
        $error("error_code: expected %0d, got %0d", want.err, err);
        fail_count++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] item_value;
  logic signed [DATA_W-1:0] item_priority;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] head_value;
  logic                     is_empty;
  logic [COUNT_W-1:0]       entry_count;
  logic [ERR_W-1:0]         error_code;

  // Set per phase to give stretches with no idling on either side.
  bit quiet;
  sorted_queue_scoreboard board = new;

  stable_min_priority_queue_top #(
    .CAPACITY(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .item_value(item_value),
    .item_priority(item_priority),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head_value(head_value),
    .is_empty(is_empty),
    .entry_count(entry_count),
    .error_code(error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_idle();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Priority drawn in one of three styles: narrow for ties, full range, or extremes.
  function automatic logic signed [DATA_W-1:0] pick_priority(int style);
    case (style)
      0: return $urandom_range(0, 3);
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          3: return -1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Presents one word after an optional gap and holds it until taken.
  task automatic send_word(logic [OP_W-1:0] code, logic signed [DATA_W-1:0] value,
                           logic signed [DATA_W-1:0] prio);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    item_value <= value;
    item_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_operation(code, value, prio);
  endtask

  // Result side: checks every word taken and stalls in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        board.check_status(head_value, is_empty, entry_count, error_code);
      if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 2) == 0) stall_left = pick_idle();
      out_stall <= (stall_left > 0);
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timed out after %0d cycles without a word moving.", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int sent;
    int phase_len;
    int mode;
    int prio_style;
    int r;
    logic [OP_W-1:0] code;
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_ENQUEUE;
    item_value <= '0;
    item_priority <= '0;
    quiet = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty store: dequeue error, clear and the unused code.
    send_word(OP_DEQUEUE, 5, 5);
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_NOP, 0, 0);
    // Extremes of value and priority, then ties at zero and at the top priority.
    send_word(OP_ENQUEUE, 32'sh7fffffff, 32'sh7fffffff);
    send_word(OP_ENQUEUE, 32'sh80000000, 32'sh80000000);
    send_word(OP_ENQUEUE, 0, 0);
    send_word(OP_ENQUEUE, -1, -1);
    send_word(OP_ENQUEUE, 11, 0);
    send_word(OP_ENQUEUE, 12, 0);
    send_word(OP_ENQUEUE, 13, 32'sh7fffffff);
    // Fill to capacity with falling priorities so each insert walks far back.
    for (int i = 0; i < QUEUE_DEPTH - 7; i++) send_word(OP_ENQUEUE, 100 + i, 50 - i);
    send_word(OP_ENQUEUE, 999, -7);
    send_word(OP_NOP, 0, 0);
    send_word(OP_DEQUEUE, 0, 0);
    send_word(OP_DEQUEUE, 0, 0);
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_DEQUEUE, 0, 0);

    // Random phases that lean towards filling, draining or a mix.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      phase_len = $urandom_range(10, 40);
      mode = $urandom_range(0, 2);
      prio_style = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 3) code = OP_CLEAR;
        else if (r < 5) code = OP_NOP;
        else begin
          r = $urandom_range(0, 99);
          case (mode)
            0: code = (r < 85) ? OP_ENQUEUE : OP_DEQUEUE;
            1: code = (r < 85) ? OP_DEQUEUE : OP_ENQUEUE;
            default: code = (r < 52) ? OP_ENQUEUE : OP_DEQUEUE;
          endcase
        end
        send_word(code, $urandom, pick_priority(prio_style));
        sent++;
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // Drain the outstanding results, then watch for stray words.
    while (board.pending_status.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d enqueues, %0d dequeues, %0d clears and %0d unused-code words.",
             board.enq_words, board.deq_words, board.clear_words, board.nop_words);
    $display("Rejected %0d enqueues when full and %0d dequeues when empty; peak occupancy %0d.",
             board.full_rejects, board.empty_rejects, board.peak_count);
    if (board.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/smpq_pkg.sv
hdl/stable_min_priority_queue_top.sv
tb/tb_top.sv
